/* sv/abd_pkg.sv */
`default_nettype none
package abd_pkg;

   localparam int NumGroups = 15;
   localparam int GroupBits = 4;
   localparam int RoundBits = 4;

   typedef enum logic [0:0] {
      CMD_LOAD    = 1'b0,
      CMD_DECRYPT = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  key_group;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
   } item_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p = a;
      for (int k = 0; k < 4; k++) begin
         if (b[k]) acc = acc ^ p;
         p = xtime(p);
      end
      gmul = acc;
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] r;
      case (x)
         8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
         8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
         8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
         8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
         8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
         8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
         8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
         8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
         8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
         8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
         8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
         8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
         8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
         8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
         8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
         8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
         8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
         8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
         8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
         8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
         8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
         8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
         8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
         8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
         8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
         8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
         8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
         8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
         8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
         8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
         8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
         8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
         8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
         8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
         8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
         8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
         8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
         8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
         8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
         8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
         8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
         8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
         8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
         8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
         8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
         8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
         8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
         8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
         8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
         8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
         8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
         8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
         8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
         8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
         8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
         8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
         8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
         8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
         8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
         8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
         8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
         8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
         8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
         8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
         default: r = 8'h00;
      endcase
      inv_sbox = r;
   endfunction

   // td0 entry: {0e,09,0d,0b} * invsbox(x)
   function automatic logic [31:0] td0(input logic [7:0] x);
      logic [7:0] s;
      s = inv_sbox(x);
      td0 = {gmul(s, 4'he), gmul(s, 4'h9), gmul(s, 4'hd), gmul(s, 4'hb)};
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

endpackage
`default_nettype wire

/* sv/aes_block_decrypt_top.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | cmd, key_group, in_word0..3
// rsp     | out       | rsp_valid/rsp_stall  | out_word0..3
// csr     | in        | csr_wr_en            | csr_wr_data (key_length_bytes)
// a decrypt runs in the back end one round per cycle through a single td round
// unit; a key load is written straight into the key store.
// reset is synchronous; the key store is not cleared and must be loaded.
// a two-entry queue lets requests land while the back end works or rsp stalls.
`default_nettype none
module aes_block_decrypt_top
   import abd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_cmd,
   input  wire logic [3:0]  req_key_group,
   input  wire logic [31:0] req_in_word0,
   input  wire logic [31:0] req_in_word1,
   input  wire logic [31:0] req_in_word2,
   input  wire logic [31:0] req_in_word3,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_word0,
   output logic [31:0]      rsp_out_word1,
   output logic [31:0]      rsp_out_word2,
   output logic [31:0]      rsp_out_word3,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   logic [5:0]   key_len_ff;
   item_type     req_item, q_item;
   logic         q_valid, q_stall;
   logic [127:0] out_data;

   always_ff @(posedge clock) begin
      if (reset) key_len_ff <= 6'd16;
      else if (csr_wr_en) key_len_ff <= csr_wr_data;
   end

   assign req_item = '{cmd: req_cmd, key_group: req_key_group, word0: req_in_word0,
                       word1: req_in_word1, word2: req_in_word2, word3: req_in_word3};

   abd_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_stall(req_stall), .in_item(req_item),
      .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
   );

   abd_back u_back (
      .clock(clock), .reset(reset), .key_len(key_len_ff),
      .q_valid(q_valid), .q_stall(q_stall), .q_item(q_item),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .out_data(out_data)
   );

   assign rsp_out_word0 = out_data[127:96];
   assign rsp_out_word1 = out_data[95:64];
   assign rsp_out_word2 = out_data[63:32];
   assign rsp_out_word3 = out_data[31:0];

endmodule
`default_nettype wire

/* sv/abd_front.sv */
`default_nettype none
module abd_front
   import abd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_stall,
   input  wire item_type in_item,
   output logic          q_valid,
   input  wire logic     q_stall,
   output item_type      q_item
);

   // two-entry queue between front and back
   item_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall = (cnt_ff == 2'd2);
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && !q_stall;
   assign q_item   = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end

endmodule
`default_nettype wire

/* sv/abd_back.sv */
`default_nettype none
module abd_back
   import abd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [5:0]  key_len,
   input  wire logic        q_valid,
   output logic             q_stall,
   input  wire item_type    q_item,
   output logic             out_valid,
   input  wire logic        out_stall,
   output logic [127:0]     out_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_ROUND = 4'b0100,
      ST_LAST  = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [127:0]          key_mem [NumGroups];
   logic [127:0]          key_rd_ff;
   logic [GroupBits-1:0]  rd_addr;
   logic [RoundBits-1:0]  round_ff, round_in, nr;
   logic [127:0]          st_ff, st_in;
   logic [127:0]          res_ff;
   logic                  res_valid_ff, res_valid_in;
   logic [31:0]           s [4];
   logic [31:0]           t [4];
   logic [31:0]           f [4];
   logic                  take;

   assign nr = (key_len >= 6'd32) ? 4'd14 : (key_len >= 6'd24) ? 4'd12 : 4'd10;

   always_comb begin
      for (int c = 0; c < 4; c++) s[c] = st_ff[127-32*c -: 32];
      for (int c = 0; c < 4; c++) begin
         t[c] = td0(s[c][31:24]) ^ rotr(td0(s[(c+3)%4][23:16]), 8) ^
                rotr(td0(s[(c+2)%4][15:8]), 16) ^ rotr(td0(s[(c+1)%4][7:0]), 24);
         f[c] = {inv_sbox(s[c][31:24]), inv_sbox(s[(c+3)%4][23:16]),
                 inv_sbox(s[(c+2)%4][15:8]), inv_sbox(s[(c+1)%4][7:0])};
      end
   end

   // idle takes a load at once, and a decrypt only when the result slot is free or draining
   assign take    = (state_ff == ST_IDLE) && q_valid &&
                    (q_item.cmd == CMD_LOAD || !res_valid_ff || !out_stall);
   assign q_stall = !take;
   // fetch the key group that the next cycle's round will use
   assign rd_addr = (state_ff == ST_IDLE) ? 4'd0 : round_in;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      st_in        = st_ff;
      res_valid_in = res_valid_ff && out_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && q_item.cmd == CMD_DECRYPT) begin
               state_in = ST_FETCH;
               st_in    = {q_item.word0, q_item.word1, q_item.word2, q_item.word3};
               round_in = 4'd1;
            end
         end
         ST_FETCH: begin
            st_in    = st_ff ^ key_rd_ff;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == nr) begin
               state_in = ST_LAST;
            end else begin
               st_in    = {t[0], t[1], t[2], t[3]} ^ key_rd_ff;
               round_in = round_ff + 4'd1;
            end
         end
         ST_LAST: begin
            state_in     = ST_IDLE;
            res_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         res_valid_ff <= res_valid_in;
      end
      st_ff     <= st_in;
      key_rd_ff <= key_mem[rd_addr];
      if (state_ff == ST_LAST) res_ff <= {f[0], f[1], f[2], f[3]} ^ key_rd_ff;
      if (take && q_item.cmd == CMD_LOAD && q_item.key_group != 4'd15)
         key_mem[q_item.key_group] <= {q_item.word0, q_item.word1,
                                       q_item.word2, q_item.word3};
   end

   assign out_valid = res_valid_ff;
   assign out_data  = res_ff;

endmodule
`default_nettype wire

/* sv/abd_checker.sv */
`default_nettype none
module abd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_out_word0
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_word0))
      else $error("rsp changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   a_handshake_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_stall, rsp_valid}))
      else $error("handshake signal unknown");

endmodule

bind aes_block_decrypt_top abd_checker u_abd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_out_word0(rsp_out_word0)
);
`default_nettype wire
